@@ src/sdspi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Shared command codes, result type and state encodings.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // Input command codes.
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_RXB   = 3'd3;
  localparam logic [2:0] CMD_LOAD  = 3'd4;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_IDLE = 2'd1;
  localparam logic [1:0] ST_RD_FAIL = 2'd2;
  localparam logic [1:0] ST_WR_FAIL = 2'd3;

  // Configuration register addresses (word index).
  localparam logic [1:0] REG_RESP  = 2'd0;
  localparam logic [1:0] REG_V2    = 2'd1;
  localparam logic [1:0] REG_V1    = 2'd2;
  localparam logic [1:0] REG_WAIT  = 2'd3;

  // Sequence phases, one-hot.
  typedef enum logic [24:0] {
    PH_IDLE  = 25'h0000001, PH_WAKE  = 25'h0000002, PH_CMD0  = 25'h0000004,
    PH_REL0  = 25'h0000008, PH_CMD8  = 25'h0000010, PH_OCR1  = 25'h0000020,
    PH_V2    = 25'h0000040, PH_CMD58 = 25'h0000080, PH_OCR2  = 25'h0000100,
    PH_PROBE = 25'h0000200, PH_V1    = 25'h0000400, PH_CMD16 = 25'h0000800,
    PH_END   = 25'h0001000, PH_RCMD  = 25'h0002000, PH_RREL  = 25'h0004000,
    PH_RTOK  = 25'h0008000, PH_RDATA = 25'h0010000, PH_RCRC  = 25'h0020000,
    PH_WCMD  = 25'h0040000, PH_WREL  = 25'h0080000, PH_WTOK  = 25'h0100000,
    PH_WDATA = 25'h0200000, PH_WCRC  = 25'h0400000, PH_WRESP = 25'h0800000,
    PH_WBUSY = 25'h1000000
  } phase_t;

  // Command framing sub-state, one-hot.
  typedef enum logic [4:0] {
    LK_NONE  = 5'b00001, LK_DESEL = 5'b00010, LK_SEL = 5'b00100,
    LK_FRAME = 5'b01000, LK_POLL  = 5'b10000
  } link_t;

  // One result item.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_card;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [1:0] status;
    logic [3:0] card_type;
  } result_t;

endpackage : sdspi_pkg
`default_nettype wire

@@ src/sd_card_spi_host_sequencer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// Byte-level SD/MMC SPI-mode init, block read and block write sequencer.
// ----------------------------------------------------------------------------
// Each accepted item (a start command, a received SPI byte or a write-buffer
// load) produces exactly one result item, which names the next byte to shift
// out, the chip-select level and any read data.
// A new item is accepted every cycle while the result register is empty or
// being drained, so the sustained rate is one item per clock. The write
// buffer is a RAM with a registered read; the byte to be sent next is always
// read one item ahead, so the RAM port never throttles the rate.
module sd_card_spi_host_sequencer_top
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES      = 512,
  parameter int WAKE_DUMMY_BYTES = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [31:0] in_block_address,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic [8:0]  in_buffer_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_select_card,
  output logic             out_rx_valid,
  output logic [7:0]       out_rx_byte,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic [3:0]       out_card_type,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam logic [CW-1:0] BLK      = CW'(BLOCK_BYTES);
  localparam logic [CW-1:0] WAKE_CNT = CW'(WAKE_DUMMY_BYTES);

  // Configuration registers.
  logic [7:0]  resp_tries_r;
  logic [15:0] v2_tries_r, v1_tries_r, wait_lim_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_tries_r <= 8'd10;
      v2_tries_r   <= 16'd12000;
      v1_tries_r   <= 16'd25000;
      wait_lim_r   <= 16'hFFFF;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        REG_RESP: resp_tries_r <= cfg_pwdata[7:0];
        REG_V2:   v2_tries_r   <= cfg_pwdata[15:0];
        REG_V1:   v1_tries_r   <= cfg_pwdata[15:0];
        REG_WAIT: wait_lim_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      REG_RESP: cfg_prdata = {24'd0, resp_tries_r};
      REG_V2:   cfg_prdata = {16'd0, v2_tries_r};
      REG_V1:   cfg_prdata = {16'd0, v1_tries_r};
      REG_WAIT: cfg_prdata = {16'd0, wait_lim_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // Handshake: the output register frees when drained.
  logic acc;
  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  // Sequencer state.
  phase_t      phase_r, phase_nxt;
  link_t       link_r, link_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;
  logic [15:0] wcnt_r, wcnt_nxt;
  logic [7:0]  pcnt_r, pcnt_nxt;
  logic [15:0] rcnt_r, rcnt_nxt;
  logic [5:0]  cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic        app_r, app_nxt;
  logic [7:0]  ocr0_r, ocr0_nxt, ocr2_r, ocr2_nxt;
  logic [3:0]  dtype_r, dtype_nxt;
  result_t     res_r, res;

  // Write buffer; the read address is the next data byte index.
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          ram_we;
  logic          byp_hit_r;
  logic [7:0]    byp_data_r;
  logic [7:0]    wr_byte;

  assign ram_we = acc && in_cmd == CMD_LOAD && {1'b0, in_buffer_index} < 10'(BLOCK_BYTES);

  sdspi_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_wbuf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_buffer_index)),
    .wdata (in_byte_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next read address: the entry that a following WTOK/WDATA step will send.
  // Without a transfer the address follows the held state, not the idle inputs.
  always_comb begin
    if (acc) begin
      if (phase_nxt == PH_WDATA) ram_raddr = AW'(bcnt_nxt + CW'(1));
      else                       ram_raddr = '0;
    end else if (phase_r == PH_WDATA) begin
      ram_raddr = AW'(bcnt_r + CW'(1));
    end else begin
      ram_raddr = '0;
    end
  end

  // A load to the entry being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= ram_we && (AW'(in_buffer_index) == ram_raddr);
    end
    byp_data_r <= in_byte_in;
  end

  assign wr_byte = byp_hit_r ? byp_data_r : ram_rdata;

  // Frame byte of the current command.
  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic app,
                                            input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0]  c;
    logic [31:0] a;
    begin
      c = app ? 8'h77 : {2'b01, idx};
      a = app ? 32'd0 : arg;
      case (k)
        3'd0:    frame_byte = c;
        3'd1:    frame_byte = a[31:24];
        3'd2:    frame_byte = a[23:16];
        3'd3:    frame_byte = a[15:8];
        3'd4:    frame_byte = a[7:0];
        default: frame_byte = (c == 8'h40) ? 8'h95 : (c == 8'h48) ? 8'h87 : 8'h01;
      endcase
    end
  endfunction

  // Combinational step.
  always_comb begin
    logic [7:0]  b;
    logic [15:0] rinc;
    logic [15:0] winc;
    logic        fin, ok_r;
    b = in_byte_in;
    phase_nxt = phase_r; link_nxt = link_r; bcnt_nxt = bcnt_r; wcnt_nxt = wcnt_r;
    pcnt_nxt = pcnt_r; rcnt_nxt = rcnt_r; cidx_nxt = cidx_r; carg_nxt = carg_r;
    app_nxt = app_r; ocr0_nxt = ocr0_r; ocr2_nxt = ocr2_r; dtype_nxt = dtype_r;
    res = '0;
    rinc = rcnt_r + 16'd1;
    winc = wcnt_r + 16'd1;
    fin = 1'b0; ok_r = 1'b0;
    case (in_cmd)
      CMD_INIT: begin
        dtype_nxt = '0; phase_nxt = PH_WAKE; bcnt_nxt = '0; link_nxt = LK_NONE;
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
      end
      CMD_READ, CMD_WRITE: begin
        phase_nxt = (in_cmd == CMD_READ) ? PH_RCMD : PH_WCMD;
        cidx_nxt = (in_cmd == CMD_READ) ? 6'd17 : 6'd24;
        carg_nxt = in_block_address; app_nxt = 1'b0; link_nxt = LK_DESEL;
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
      end
      CMD_RXB: if (phase_r != PH_IDLE) begin
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.select_card = 1'b1;
        case (link_r)
          LK_DESEL: link_nxt = LK_SEL;
          LK_SEL: begin
            bcnt_nxt = '0; link_nxt = LK_FRAME;
            res.tx_byte = frame_byte(3'd0, app_r, cidx_r, carg_r);
          end
          LK_FRAME: begin
            bcnt_nxt = bcnt_r + CW'(1);
            if (bcnt_r < CW'(5)) begin
              res.tx_byte = frame_byte(3'(bcnt_nxt), app_r, cidx_r, carg_r);
            end else begin
              pcnt_nxt = '0; link_nxt = LK_POLL;
            end
          end
          LK_POLL: begin
            pcnt_nxt = b[7] ? pcnt_r + 8'd1 : pcnt_r;
            if (b[7] && pcnt_nxt != resp_tries_r) begin
              // Keep polling.
            end else begin
              link_nxt = LK_NONE;
              if (app_r && b <= 8'd1) begin
                app_nxt = 1'b0; link_nxt = LK_DESEL; res.select_card = 1'b0;
              end else begin
                ok_r = 1'b1;
              end
            end
          end
          default: begin
            case (phase_r)
              PH_WAKE: begin
                bcnt_nxt = bcnt_r + CW'(1); res.select_card = 1'b0;
                if (bcnt_nxt >= WAKE_CNT) begin
                  phase_nxt = PH_CMD0; cidx_nxt = 6'd0; carg_nxt = '0; app_nxt = 1'b0;
                  link_nxt = LK_DESEL;
                end
              end
              PH_REL0: begin
                phase_nxt = PH_CMD8; cidx_nxt = 6'd8; carg_nxt = 32'h1AA; app_nxt = 1'b0;
                link_nxt = LK_DESEL; res.select_card = 1'b0;
              end
              PH_OCR1, PH_OCR2: begin
                if (bcnt_r[1:0] == 2'd0) ocr0_nxt = b;
                if (bcnt_r[1:0] == 2'd2) ocr2_nxt = b;
                bcnt_nxt = bcnt_r + CW'(1);
                if (bcnt_nxt >= CW'(4)) begin
                  res.select_card = 1'b0;
                  if (phase_r == PH_OCR2) begin
                    dtype_nxt = ocr0_r[6] ? 4'd12 : 4'd4; phase_nxt = PH_END;
                  end else if (ocr2_r == 8'h01 && b == 8'hAA && v2_tries_r != 0) begin
                    rcnt_nxt = '0; phase_nxt = PH_V2; cidx_nxt = 6'd41;
                    carg_nxt = 32'h40000000; app_nxt = 1'b1; link_nxt = LK_DESEL;
                  end else begin
                    phase_nxt = PH_END;
                  end
                end
              end
              PH_END: fin = 1'b1;
              PH_RREL: begin wcnt_nxt = '0; phase_nxt = PH_RTOK; end
              PH_RTOK: begin
                wcnt_nxt = winc;
                if (winc >= wait_lim_r) begin
                  fin = 1'b1; res.status = ST_RD_FAIL;
                end else if (b == 8'hFE) begin
                  phase_nxt = PH_RDATA; bcnt_nxt = '0;
                end
              end
              PH_RDATA: begin
                res.rx_valid = 1'b1; res.rx_byte = b;
                bcnt_nxt = bcnt_r + CW'(1);
                if (bcnt_nxt >= BLK) begin phase_nxt = PH_RCRC; bcnt_nxt = '0; end
              end
              PH_RCRC: begin
                bcnt_nxt = bcnt_r + CW'(1);
                if (bcnt_nxt >= CW'(2)) fin = 1'b1;
              end
              PH_WREL: begin phase_nxt = PH_WTOK; res.tx_byte = 8'hFE; end
              PH_WTOK: begin
                phase_nxt = PH_WDATA; bcnt_nxt = '0; res.tx_byte = wr_byte;
              end
              PH_WDATA: begin
                bcnt_nxt = bcnt_r + CW'(1);
                if (bcnt_nxt < BLK) res.tx_byte = wr_byte;
                else begin phase_nxt = PH_WCRC; bcnt_nxt = '0; end
              end
              PH_WCRC: begin
                bcnt_nxt = bcnt_r + CW'(1);
                if (bcnt_nxt >= CW'(2)) phase_nxt = PH_WRESP;
              end
              PH_WRESP: begin
                if ((b & 8'h05) != 8'h05) begin
                  fin = 1'b1; res.status = ST_WR_FAIL;
                end else begin
                  wcnt_nxt = '0; phase_nxt = PH_WBUSY;
                end
              end
              PH_WBUSY: begin
                wcnt_nxt = winc;
                if (winc >= wait_lim_r) begin
                  fin = 1'b1; res.status = ST_WR_FAIL;
                end else if (b == 8'hFF) begin
                  fin = 1'b1;
                end
              end
              default: ;
            endcase
          end
        endcase
        // Response handling after a polled R1.
        if (ok_r) begin
          case (phase_r)
            PH_CMD0: begin
              if (b == 8'd1) phase_nxt = PH_REL0;
              else begin fin = 1'b1; res.status = ST_NO_IDLE; end
            end
            PH_CMD8: begin
              if (b == 8'd1) begin phase_nxt = PH_OCR1; bcnt_nxt = '0; end
              else begin
                phase_nxt = PH_PROBE; cidx_nxt = 6'd41; carg_nxt = '0; app_nxt = 1'b1;
                link_nxt = LK_DESEL; res.select_card = 1'b0;
              end
            end
            PH_V2: begin
              res.select_card = 1'b0;
              if (b == 8'd0) begin
                phase_nxt = PH_CMD58; cidx_nxt = 6'd58; carg_nxt = '0; app_nxt = 1'b0;
                link_nxt = LK_DESEL;
              end else begin
                rcnt_nxt = rinc;
                if (rinc >= v2_tries_r) phase_nxt = PH_END;
                else begin
                  cidx_nxt = 6'd41; carg_nxt = 32'h40000000; app_nxt = 1'b1;
                  link_nxt = LK_DESEL;
                end
              end
            end
            PH_CMD58: begin
              if (b == 8'd0) begin phase_nxt = PH_OCR2; bcnt_nxt = '0; end
              else begin phase_nxt = PH_END; res.select_card = 1'b0; end
            end
            PH_PROBE, PH_V1: begin
              res.select_card = 1'b0;
              if (phase_r == PH_PROBE) begin
                dtype_nxt = (b <= 8'd1) ? 4'd2 : 4'd1;
                rcnt_nxt = '0;
              end else begin
                rcnt_nxt = rinc;
              end
              if (phase_r == PH_V1 && b == 8'd0) begin
                phase_nxt = PH_CMD16; cidx_nxt = 6'd16; carg_nxt = 32'(BLOCK_BYTES);
                app_nxt = 1'b0; link_nxt = LK_DESEL;
              end else if ((phase_r == PH_PROBE && v1_tries_r == 0) ||
                           (phase_r == PH_V1 && rinc >= v1_tries_r)) begin
                dtype_nxt = '0; phase_nxt = PH_END;
              end else begin
                phase_nxt = PH_V1; link_nxt = LK_DESEL; carg_nxt = '0;
                if (dtype_nxt == 4'd2) begin cidx_nxt = 6'd41; app_nxt = 1'b1; end
                else begin cidx_nxt = 6'd1; app_nxt = 1'b0; end
              end
            end
            PH_CMD16: begin
              if (b != 8'd0) dtype_nxt = '0;
              phase_nxt = PH_END; res.select_card = 1'b0;
            end
            PH_RCMD: begin
              if (b != 8'd0) begin fin = 1'b1; res.status = ST_RD_FAIL; end
              else phase_nxt = PH_RREL;
            end
            PH_WCMD: begin
              if (b != 8'd0) begin fin = 1'b1; res.status = ST_WR_FAIL; end
              else phase_nxt = PH_WREL;
            end
            default: fin = 1'b1;
          endcase
        end
        if (fin) begin
          phase_nxt = PH_IDLE; link_nxt = LK_NONE; res.done_res = 1'b1;
          res.tx_valid = 1'b0; res.tx_byte = '0; res.select_card = 1'b0;
        end
      end
      default: ;
    endcase
    res.card_type = dtype_nxt;
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; link_r <= LK_NONE; bcnt_r <= '0; wcnt_r <= '0;
      pcnt_r <= '0; rcnt_r <= '0; cidx_r <= '0; carg_r <= '0; app_r <= 1'b0;
      ocr0_r <= '0; ocr2_r <= '0; dtype_r <= '0; out_valid <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt; link_r <= link_nxt; bcnt_r <= bcnt_nxt;
        wcnt_r <= wcnt_nxt; pcnt_r <= pcnt_nxt; rcnt_r <= rcnt_nxt;
        cidx_r <= cidx_nxt; carg_r <= carg_nxt; app_r <= app_nxt;
        ocr0_r <= ocr0_nxt; ocr2_r <= ocr2_nxt; dtype_r <= dtype_nxt;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) res_r <= res;
  end

  assign out_tx_valid    = res_r.tx_valid;
  assign out_tx_byte     = res_r.tx_byte;
  assign out_select_card = res_r.select_card;
  assign out_rx_valid    = res_r.rx_valid;
  assign out_rx_byte     = res_r.rx_byte;
  assign out_done_res    = res_r.done_res;
  assign out_status      = res_r.status;
  assign out_card_type   = res_r.card_type;

  // A completed operation always returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.done_res |=> phase_r == PH_IDLE) else $error("done without idle");
  // Read data only appears while selected and exchanging.
  a_rx_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_valid |-> out_tx_valid && out_select_card)
    else $error("rx data outside exchange");
  // Done never requests another exchange.
  a_done_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_tx_valid) else $error("done with tx");
  // Link framing only runs outside idle.
  a_link_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> link_r == LK_NONE) else $error("link active in idle");

endmodule : sd_card_spi_host_sequencer_top
`default_nettype wire

@@ src/sdspi_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SD SPI generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module sdspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : sdspi_ram
`default_nettype wire
